// ===== hdl/period_deadline_monitor_assert.svh =====
// Assertion macros for the period deadline monitor.
`ifndef PERIOD_DEADLINE_MONITOR_ASSERT_SVH
`define PERIOD_DEADLINE_MONITOR_ASSERT_SVH
`ifndef SYNTHESIS
`define PDM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PDM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PDM_ASSERT(lbl, prop, msg)
`define PDM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/pdm_pkg.sv =====
package pdm_pkg;

  localparam int unsigned CyclesPerUs = 200;
  localparam int unsigned StampW      = 32;
  localparam int unsigned UsW         = 25;
  localparam int unsigned SumW        = 64;
  localparam int unsigned CpuW        = $clog2(CyclesPerUs + 1);
  localparam int unsigned TgtW        = UsW + CpuW;
  localparam int unsigned CntW        = $clog2(SumW);

  // cycles to microseconds by reciprocal multiply, exact for any ConvW-bit operand
  localparam int unsigned ConvW     = (TgtW > StampW + 1) ? TgtW : StampW + 1;
  localparam int unsigned RecipW    = ConvW + 1;
  localparam int unsigned ProdW     = ConvW + RecipW;
  localparam int unsigned ConvShift = ConvW + $clog2(CyclesPerUs);
  localparam int unsigned QuotW     = ProdW - ConvShift;
  localparam logic [RecipW-1:0] UsRecip =
    RecipW'(((64'd1 << ConvShift) + 64'(CyclesPerUs - 1)) / 64'(CyclesPerUs));

  localparam logic [1:0] RegEnable    = 2'd0;
  localparam logic [1:0] RegDeadline  = 2'd1;
  localparam logic [1:0] RegThreshold = 2'd2;
  localparam logic [1:0] RegTarget    = 2'd3;

  localparam logic ReqTick  = 1'b0;
  localparam logic ReqClear = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [StampW-1:0] timestamp;
  } in_t;

  typedef struct packed {
    logic [StampW-1:0] ticks_total;
    logic [UsW-1:0]    last_per_us;
    logic [UsW-1:0]    per_min_us;
    logic [UsW-1:0]    per_max_us;
    logic [UsW-1:0]    per_mean_us;
    logic [UsW-1:0]    jitter_peak_us;
    logic [StampW-1:0] miss_tally;
    logic [StampW-1:0] consecutive_misses;
    logic              deadline_violation;
    logic              miss_alert;
  } out_t;

  typedef struct packed {
    logic              start;
    logic              wide;
    logic [SumW-1:0]   dividend;
    logic [StampW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [SumW-1:0] quot;
  } div_rsp_t;

  function automatic logic [UsW-1:0] sat_us(input logic [SumW-1:0] v);
    logic [UsW-1:0] r;
    if (|v[SumW-1:UsW]) begin
      r = '1;
    end else begin
      r = v[UsW-1:0];
    end
    return r;
  endfunction

  function automatic logic [StampW-1:0] sat_inc(input logic [StampW-1:0] v);
    logic [StampW-1:0] r;
    if (&v) begin
      r = v;
    end else begin
      r = v + StampW'(1);
    end
    return r;
  endfunction

endpackage

// ===== hdl/pdm_div.sv =====
module pdm_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pdm_pkg::div_req_t req_i,
  output pdm_pkg::div_rsp_t rsp_o
);
  import pdm_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [SumW-1:0]     dq_q, dq_d;
  logic [StampW-1:0]   rem_q, rem_d;
  logic [StampW-1:0]   den_q, den_d;
  logic [StampW:0]     rem_sh;
  logic [StampW:0]     diff;
  logic                ge;

  // restoring radix-2 step; quotient bits shift in behind the dividend
  assign rem_sh = {rem_q, dq_q[SumW-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      rem_d  = '0;
      den_d  = req_i.divisor;
      if (req_i.wide) begin
        dq_d  = req_i.dividend;
        cnt_d = CntW'(SumW - 1);
      end else begin
        dq_d  = {req_i.dividend[StampW-1:0], {(SumW - StampW){1'b0}}};
        cnt_d = CntW'(StampW - 1);
      end
    end else if (busy_q) begin
      dq_d  = {dq_q[SumW-2:0], ge};
      rem_d = ge ? diff[StampW-1:0] : rem_sh[StampW-1:0];
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = dq_q;

endmodule

// ===== hdl/period_deadline_monitor.sv =====
// A transfer passes ST_UPD, ST_PER for a measured tick, and ST_STATS; while fewer than two
// ticks are held it then goes to ST_OUT, else on through ST_MIN, ST_MAX, ST_JIT, ST_AVG, which
// waits for the 64-step average division, and ST_AVG2 to ST_OUT. Transfers are taken one at a
// time, in ST_IDLE only; the next is taken while the previous result waits at the output.
// Reset (asynchronous, active low) clears the statistics, disables the monitor and
// loads deadline 5000 us, threshold 3 and target 5000 us.
module period_deadline_monitor (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pdm_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pdm_pkg::out_t  out_data_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [31:0]    cfg_data_i
);
  import pdm_pkg::*;

  `include "period_deadline_monitor_assert.svh"

  typedef enum logic [3:0] {
    ST_IDLE, ST_UPD, ST_PER, ST_STATS, ST_MIN, ST_MAX, ST_JIT, ST_AVG, ST_AVG2, ST_OUT
  } state_e;

  state_e            state_q, state_d;
  logic              en_q, en_d;
  logic [31:0]       dl_q, dl_d;
  logic [31:0]       thr_q, thr_d;
  logic [UsW-1:0]    tgt_us_q, tgt_us_d;

  logic              req_q, req_d;
  logic [StampW-1:0] stamp_q, stamp_d;
  logic [StampW-1:0] last_q, last_d;
  logic [StampW-1:0] ticks_q, ticks_d;
  logic [StampW-1:0] short_q, short_d;
  logic [StampW-1:0] long_q, long_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [StampW-1:0] misses_q, misses_d;
  logic [StampW-1:0] run_q, run_d;
  logic [TgtW-1:0]   tgt_q, tgt_d;
  logic [TgtW-1:0]   jit_q, jit_d;
  logic [ConvW-1:0]  conv_q, conv_d;
  logic [UsW-1:0]    per_us_q, per_us_d;
  logic [UsW-1:0]    min_us_q, min_us_d;
  logic [UsW-1:0]    max_us_q, max_us_d;
  logic [UsW-1:0]    avg_us_q, avg_us_d;
  logic [UsW-1:0]    jit_us_q, jit_us_d;
  logic              alert_q, alert_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic [StampW-1:0] delta;
  logic [SumW:0]     sum_add;
  logic [TgtW-1:0]   long_x, short_x, hi, lo;
  logic [ProdW-1:0]  conv_prod;
  logic [QuotW-1:0]  conv_quot;

  assign delta   = stamp_q - last_q;
  assign sum_add = {1'b0, sum_q} + (SumW + 1)'(delta);
  assign long_x  = TgtW'(long_q);
  assign short_x = TgtW'(short_q);
  assign hi      = (long_x > tgt_q) ? long_x - tgt_q : '0;
  assign lo      = (short_x < tgt_q) ? tgt_q - short_x : '0;

  // shared cycles-to-microseconds unit, one conversion per cycle
  assign conv_prod = {{RecipW{1'b0}}, conv_q} * {{ConvW{1'b0}}, UsRecip};
  assign conv_quot = conv_prod[ProdW-1:ConvShift];

  pdm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    logic [StampW-1:0] pus;
    logic [StampW-1:0] run_inc;
    state_d     = state_q;
    en_d        = en_q;
    dl_d        = dl_q;
    thr_d       = thr_q;
    tgt_us_d    = tgt_us_q;
    req_d       = req_q;
    stamp_d     = stamp_q;
    last_d      = last_q;
    ticks_d     = ticks_q;
    short_d     = short_q;
    long_d      = long_q;
    sum_d       = sum_q;
    misses_d    = misses_q;
    run_d       = run_q;
    tgt_d       = tgt_q;
    jit_d       = jit_q;
    conv_d      = conv_q;
    per_us_d    = per_us_q;
    min_us_d    = min_us_q;
    max_us_d    = max_us_q;
    avg_us_d    = avg_us_q;
    jit_us_d    = jit_us_q;
    alert_d     = alert_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    div_req     = '0;
    pus         = StampW'(conv_quot);
    run_inc     = sat_inc(run_q);

    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegEnable:    en_d     = cfg_data_i[0];
        RegDeadline:  dl_d     = cfg_data_i;
        RegThreshold: thr_d    = cfg_data_i;
        RegTarget:    tgt_us_d = cfg_data_i[UsW-1:0];
        default:      ;
      endcase
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i.req_type;
          stamp_d = in_data_i.timestamp;
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        per_us_d = '0;
        alert_d  = 1'b0;
        tgt_d    = TgtW'(tgt_us_q) * TgtW'(CyclesPerUs);
        state_d  = ST_STATS;
        if (req_q == ReqClear) begin
          last_d   = '0;
          ticks_d  = '0;
          short_d  = '1;
          long_d   = '0;
          sum_d    = '0;
          misses_d = '0;
          run_d    = '0;
        end else if (en_q) begin
          last_d = stamp_q;
          if (ticks_q == '0) begin
            ticks_d = StampW'(1);
          end else begin
            ticks_d = sat_inc(ticks_q);
            sum_d   = sum_add[SumW] ? '1 : sum_add[SumW-1:0];
            if (delta < short_q) short_d = delta;
            if (delta > long_q) long_d = delta;
            conv_d  = ConvW'(delta);
            state_d = ST_PER;
          end
        end
      end
      ST_PER: begin
        per_us_d = sat_us(SumW'(conv_quot));
        if (pus > dl_q) begin
          misses_d = sat_inc(misses_q);
          run_d    = run_inc;
          alert_d  = run_inc >= thr_q;
        end else begin
          run_d = '0;
        end
        state_d = ST_STATS;
      end
      ST_STATS: begin
        jit_d = (hi > lo) ? hi : lo;
        if (ticks_q <= StampW'(1)) begin
          min_us_d = '0;
          max_us_d = '0;
          avg_us_d = '0;
          jit_us_d = '0;
          state_d  = ST_OUT;
        end else begin
          div_req.start    = 1'b1;
          div_req.wide     = 1'b1;
          div_req.dividend = sum_q;
          div_req.divisor  = ticks_q - StampW'(1);
          conv_d           = ConvW'(short_q);
          state_d          = ST_MIN;
        end
      end
      ST_MIN: begin
        min_us_d = sat_us(SumW'(conv_quot));
        conv_d   = ConvW'(long_q);
        state_d  = ST_MAX;
      end
      ST_MAX: begin
        max_us_d = sat_us(SumW'(conv_quot));
        conv_d   = ConvW'(jit_q);
        state_d  = ST_JIT;
      end
      ST_JIT: begin
        jit_us_d = sat_us(SumW'(conv_quot));
        state_d  = ST_AVG;
      end
      ST_AVG: begin
        if (div_rsp.done) begin
          conv_d  = (|div_rsp.quot[SumW-1:ConvW]) ? '1 : div_rsp.quot[ConvW-1:0];
          state_d = ST_AVG2;
        end
      end
      ST_AVG2: begin
        avg_us_d = sat_us(SumW'(conv_quot));
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.ticks_total        = ticks_q;
          out_d.last_per_us        = per_us_q;
          out_d.per_min_us         = min_us_q;
          out_d.per_max_us         = max_us_q;
          out_d.per_mean_us        = avg_us_q;
          out_d.jitter_peak_us     = jit_us_q;
          out_d.miss_tally         = misses_q;
          out_d.consecutive_misses = run_q;
          out_d.deadline_violation = run_q >= thr_q;
          out_d.miss_alert         = alert_q;
          out_valid_d              = 1'b1;
          state_d                  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      en_q        <= 1'b0;
      dl_q        <= 32'd5000;
      thr_q       <= 32'd3;
      tgt_us_q    <= UsW'(5000);
      last_q      <= '0;
      ticks_q     <= '0;
      short_q     <= '1;
      long_q      <= '0;
      sum_q       <= '0;
      misses_q    <= '0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      en_q        <= en_d;
      dl_q        <= dl_d;
      thr_q       <= thr_d;
      tgt_us_q    <= tgt_us_d;
      last_q      <= last_d;
      ticks_q     <= ticks_d;
      short_q     <= short_d;
      long_q      <= long_d;
      sum_q       <= sum_d;
      misses_q    <= misses_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    stamp_q  <= stamp_d;
    tgt_q    <= tgt_d;
    jit_q    <= jit_d;
    conv_q   <= conv_d;
    per_us_q <= per_us_d;
    min_us_q <= min_us_d;
    max_us_q <= max_us_d;
    avg_us_q <= avg_us_d;
    jit_us_q <= jit_us_d;
    alert_q  <= alert_d;
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `PDM_ASSERT(a_div_free, div_req.start |-> !div_rsp.busy, "divider started while busy")
  `PDM_ASSERT(a_min_le_max, (ticks_q > StampW'(1)) |-> (short_q <= long_q), "min above max")
  `PDM_ASSERT(a_run_le_total, run_q <= misses_q, "miss run exceeds miss total")
  `PDM_ASSERT_NEXT(a_out_load, (state_q == ST_OUT) && !out_valid_q, out_valid_q, "result lost")

endmodule
